// ===== sv/awm_pkg.sv =====
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types, codes and helpers of the weekly alarm matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

	localparam int ENTRIES_DEF = 8;

	// Action codes carried by the input word.
	localparam logic [2:0] ACT_TICK      = 3'd0;
	localparam logic [2:0] ACT_SNOOZE    = 3'd1;
	localparam logic [2:0] ACT_DISMISS   = 3'd2;
	localparam logic [2:0] ACT_SET       = 3'd3;
	localparam logic [2:0] ACT_CLEAR     = 3'd4;
	localparam logic [2:0] ACT_CLEAR_ALL = 3'd5;
	localparam logic [2:0] ACT_READ      = 3'd6;

	// Snooze mode codes (one-hot) and their snooze limits.
	localparam logic [3:0] MODE_ONE       = 4'h1;
	localparam logic [3:0] MODE_THREE     = 4'h2;
	localparam logic [3:0] MODE_FIVE      = 4'h4;
	localparam logic [3:0] MODE_UNLIMITED = 4'h8;
	localparam logic [7:0] LIMIT_ONE       = 8'd1;
	localparam logic [7:0] LIMIT_THREE     = 8'd3;
	localparam logic [7:0] LIMIT_FIVE      = 8'd5;
	localparam logic [7:0] LIMIT_UNLIMITED = 8'd255;

	localparam logic [7:0] MINUTE_LAST  = 8'd59;
	localparam logic [7:0] MINUTES_HOUR = 8'd60;
	localparam logic [5:0] HOUR_LAST    = 6'd23;
	localparam logic [5:0] HOURS_DAY    = 6'd24;

	// One table word, most significant field first.
	typedef struct packed {
		logic [6:0] day_mask;
		logic [3:0] snz_mode;
		logic [3:0] snooze_length;
		logic [4:0] hour;
		logic [5:0] minute;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic dismiss;
		logic snooze;
		logic wr;
		logic clr_one;
		logic clr_all;
		logic err;
		logic rd_slot;
		logic rd_scan;
		logic idx_clr;
		logic idx_inc;
		logic activate;
		logic rd_capture;
		logic load_norm;
		logic norm_step;
		logic set_ring;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       in_valid;
		logic [2:0] act;
		logic       active_valid;
		logic       snooze_ok;
		logic       weekday_zero;
		logic       in_range;
		logic       match;
		logic       idx_last;
		logic       norm_more;
		logic       out_free;
	} sts_t;

	// True when the mode is a legal one-hot code and the count is within its limit.
	function automatic logic snooze_allowed(input logic [3:0] mode, input logic [7:0] count);
		logic       ok;
		logic [7:0] limit;
		ok    = 1'b1;
		limit = LIMIT_UNLIMITED;
		unique case (mode)
			MODE_ONE:       limit = LIMIT_ONE;
			MODE_THREE:     limit = LIMIT_THREE;
			MODE_FIVE:      limit = LIMIT_FIVE;
			MODE_UNLIMITED: limit = LIMIT_UNLIMITED;
			default:        ok = 1'b0;
		endcase
		return ok && (count <= limit);
	endfunction

endpackage

// ===== sv/awm_in_if.sv =====
// ----------------------------------------------------------------------------
// awm_in_if
// Request channel of the alarm matcher: valid, ready and one input word.
// ----------------------------------------------------------------------------
interface awm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [2:0] weekday;
	logic [7:0] slot;
	logic [3:0] snooze_length;
	logic [3:0] snz_mode;
	logic [6:0] day_mask;

	modport source (
		output valid, action, hour, minute, weekday, slot,
		output snooze_length, snz_mode, day_mask,
		input  ready
	);
	modport sink (
		input  valid, action, hour, minute, weekday, slot,
		input  snooze_length, snz_mode, day_mask,
		output ready
	);
endinterface

// ===== sv/awm_out_if.sv =====
// ----------------------------------------------------------------------------
// awm_out_if
// Response channel of the alarm matcher: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface awm_out_if;
	logic       valid;
	logic       ready;
	logic       ringing;
	logic       error;
	logic [4:0] entry_hour;
	logic [5:0] entry_minute;
	logic [3:0] entry_snooze_length;
	logic [3:0] entry_snz_mode;
	logic [6:0] entry_day_mask;

	modport source (
		output valid, ringing, error, entry_hour, entry_minute,
		output entry_snooze_length, entry_snz_mode, entry_day_mask,
		input  ready
	);
	modport sink (
		input  valid, ringing, error, entry_hour, entry_minute,
		input  entry_snooze_length, entry_snz_mode, entry_day_mask,
		output ready
	);
endinterface

// ===== sv/awm_ram.sv =====
// ----------------------------------------------------------------------------
// awm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module awm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/awm_ctrl.sv =====
// ----------------------------------------------------------------------------
// awm_ctrl
// Sequencer of the alarm matcher: decodes each word and steps the datapath.
// ----------------------------------------------------------------------------
module awm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  awm_pkg::sts_t sts,
	output awm_pkg::cmd_t cmd
);
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECODE   = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_SCAN_CHK = 3'd3;
	localparam logic [2:0] ST_NORM     = 3'd4;
	localparam logic [2:0] ST_CMP      = 3'd5;
	localparam logic [2:0] ST_RD_WAIT  = 3'd6;
	localparam logic [2:0] ST_FINISH   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FINISH;
				unique case (sts.act)
					awm_pkg::ACT_TICK: begin
						if (sts.active_valid) begin
							if (sts.snooze_ok) begin
								cmd.load_norm = 1'b1;
								state_d       = ST_NORM;
							end else begin
								cmd.dismiss = 1'b1;
							end
						end else if (!sts.weekday_zero) begin
							cmd.idx_clr = 1'b1;
							state_d     = ST_SCAN;
						end
					end
					awm_pkg::ACT_SNOOZE:    cmd.snooze = 1'b1;
					awm_pkg::ACT_DISMISS:   cmd.dismiss = 1'b1;
					awm_pkg::ACT_SET: begin
						cmd.wr  = sts.in_range;
						cmd.err = !sts.in_range;
					end
					awm_pkg::ACT_CLEAR: begin
						cmd.clr_one = sts.in_range;
						cmd.err     = !sts.in_range;
					end
					awm_pkg::ACT_CLEAR_ALL: cmd.clr_all = 1'b1;
					awm_pkg::ACT_READ: begin
						if (sts.in_range) begin
							cmd.rd_slot = 1'b1;
							state_d     = ST_RD_WAIT;
						end else begin
							cmd.err = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				cmd.rd_scan = 1'b1;
				state_d     = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.match) begin
					cmd.activate = 1'b1;
					state_d      = ST_FINISH;
				end else if (sts.idx_last) begin
					state_d = ST_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_NORM: begin
				cmd.norm_step = 1'b1;
				if (!sts.norm_more) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.set_ring = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_RD_WAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== sv/awm_dp.sv =====
// ----------------------------------------------------------------------------
// awm_dp
// Datapath of the alarm matcher: word capture, alarm table, active alarm,
// snoozed-time arithmetic and the result register.
// ----------------------------------------------------------------------------
module awm_dp #(
	parameter int ENTRIES = awm_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	awm_in_if.sink         req,
	awm_out_if.source      rsp,
	input  awm_pkg::cmd_t  cmd,
	output awm_pkg::sts_t  sts
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Captured input word.
	logic [2:0] act_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [2:0] weekday_q;
	logic [7:0] slot_q;
	logic [3:0] len_q;
	logic [3:0] mode_q;
	logic [6:0] days_q;

	// Table bookkeeping and active alarm.
	logic [ENTRIES-1:0]    valid_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  rd_valid_s1;
	awm_pkg::entry_t       active_q;
	logic                  active_valid_q;
	logic [7:0]            count_q;

	// Snoozed time being normalised.
	logic [5:0] th_q;
	logic [7:0] tm_q;

	// Result being built and the result on the port.
	logic            ring_q;
	logic            err_q;
	awm_pkg::entry_t rd_q;
	logic            out_valid_q;
	logic            out_ring_q;
	logic            out_err_q;
	awm_pkg::entry_t out_rd_q;

	logic                  accept;
	logic [IDX_W-1:0]      slot_idx;
	logic [IDX_W-1:0]      ram_addr;
	logic                  ram_re;
	awm_pkg::entry_t       wr_word;
	logic [awm_pkg::ENTRY_W-1:0] ram_rdata;
	awm_pkg::entry_t       rd_word;
	logic [2:0]            day_sel;
	logic                  day_hit;
	logic [11:0]           prod;
	logic [7:0]            tm_load;
	logic                  wrap_min;
	logic [7:0]            tm_a;
	logic [5:0]            th_a;
	logic [5:0]            th_b;

	assign accept    = req.valid && cmd.in_ready;
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= req.action;
			hour_q    <= req.hour;
			minute_q  <= req.minute;
			weekday_q <= req.weekday;
			slot_q    <= req.slot;
			len_q     <= req.snooze_length;
			mode_q    <= req.snz_mode;
			days_q    <= req.day_mask;
		end
	end

	assign slot_idx = slot_q[IDX_W-1:0];
	assign ram_addr = cmd.rd_scan ? idx_q : slot_idx;
	assign ram_re   = cmd.rd_scan || cmd.rd_slot;

	always_comb begin
		wr_word               = '0;
		wr_word.day_mask      = days_q;
		wr_word.snz_mode      = mode_q;
		wr_word.snooze_length = len_q;
		wr_word.hour          = hour_q;
		wr_word.minute        = minute_q;
	end

	awm_ram #(
		.WIDTH (awm_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (wr_word),
		.rdata (ram_rdata)
	);

	// An entry never written since reset or clearing reads as zero.
	assign rd_word = rd_valid_s1 ? awm_pkg::entry_t'(ram_rdata) : '0;

	assign day_sel = weekday_q - 3'd1;
	assign day_hit = |(rd_word.day_mask & (7'b1 << day_sel));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clr_all) begin
			valid_q <= '0;
		end else if (cmd.wr) begin
			valid_q[slot_idx] <= 1'b1;
		end else if (cmd.clr_one) begin
			valid_q[slot_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_valid_s1 <= valid_q[ram_addr];
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= '0;
			active_valid_q <= 1'b0;
			count_q        <= '0;
		end else if (cmd.dismiss) begin
			active_q       <= '0;
			active_valid_q <= 1'b0;
			count_q        <= '0;
		end else if (cmd.snooze) begin
			count_q <= count_q + 8'd1;
		end else if (cmd.activate) begin
			active_q       <= rd_word;
			active_valid_q <= 1'b1;
		end
	end

	// Snoozed minute: alarm minute plus count times length, kept to 8 bits.
	assign prod    = 12'(count_q) * 12'(active_q.snooze_length);
	assign tm_load = 8'(prod + 12'(active_q.minute));

	// One normalising step: carry an hour out of the minutes, then wrap the day.
	assign wrap_min = tm_q > awm_pkg::MINUTE_LAST;
	assign tm_a     = wrap_min ? tm_q - awm_pkg::MINUTES_HOUR : tm_q;
	assign th_a     = th_q + 6'(wrap_min);
	assign th_b     = (th_a > awm_pkg::HOUR_LAST) ? th_a - awm_pkg::HOURS_DAY : th_a;

	always_ff @(posedge clk) begin
		if (cmd.load_norm) begin
			th_q <= 6'(active_q.hour);
			tm_q <= tm_load;
		end else if (cmd.norm_step) begin
			th_q <= th_b;
			tm_q <= tm_a;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q <= 1'b0;
			err_q  <= 1'b0;
			rd_q   <= '0;
		end else begin
			if (cmd.activate) begin
				ring_q <= 1'b1;
			end
			if (cmd.set_ring) begin
				ring_q <= (th_q >= 6'(hour_q)) && (tm_q >= 8'(minute_q));
			end
			if (cmd.err) begin
				err_q <= 1'b1;
			end
			if (cmd.rd_capture) begin
				rd_q <= rd_word;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_ring_q <= ring_q;
			out_err_q  <= err_q;
			out_rd_q   <= rd_q;
		end
	end

	assign rsp.valid               = out_valid_q;
	assign rsp.ringing             = out_ring_q;
	assign rsp.error               = out_err_q;
	assign rsp.entry_hour          = out_rd_q.hour;
	assign rsp.entry_minute        = out_rd_q.minute;
	assign rsp.entry_snooze_length = out_rd_q.snooze_length;
	assign rsp.entry_snz_mode      = out_rd_q.snz_mode;
	assign rsp.entry_day_mask      = out_rd_q.day_mask;

	always_comb begin
		sts              = '0;
		sts.in_valid     = req.valid;
		sts.act          = act_q;
		sts.active_valid = active_valid_q;
		sts.snooze_ok    = awm_pkg::snooze_allowed(active_q.snz_mode, count_q);
		sts.weekday_zero = weekday_q == 3'd0;
		sts.in_range     = {1'b0, slot_q} < 9'(ENTRIES);
		sts.match        = (rd_word.hour == hour_q) && (rd_word.minute == minute_q) && day_hit;
		sts.idx_last     = idx_q == IDX_W'(ENTRIES - 1);
		sts.norm_more    = tm_a > awm_pkg::MINUTE_LAST;
		sts.out_free     = !out_valid_q || rsp.ready;
	end
endmodule

// ===== sv/weekly_alarm_matcher_with_snooze.sv =====
// ----------------------------------------------------------------------------
// weekly_alarm_matcher_with_snooze
// Weekly alarm table with an active alarm, snooze counting and minute ticks.
// ----------------------------------------------------------------------------
// The block takes one request word at a time on req and returns exactly one
// result word on rsp for each. A minute tick with no alarm active walks the
// table of ENTRIES alarms in slot order through the single port of the table
// RAM, addressing each slot, then reading the registered word and comparing
// it, and stops at the first match; a tick on weekday zero skips the walk.
// A tick with an active alarm normalises the snoozed time one hour carry
// per cycle, or dismisses the alarm when its mode is illegal or its snooze
// count is over the mode's limit. The next request is taken as soon as the
// sequencer is back in its idle state, even while the previous result still
// waits on rsp. The table is empty after reset and after clear all without
// any clearing pass: each slot has a valid flag, and a slot without it reads
// as all zeros.
// ----------------------------------------------------------------------------
module weekly_alarm_matcher_with_snooze #(
	parameter int ENTRIES = awm_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	awm_in_if.sink     req,
	awm_out_if.source  rsp
);
	// Command and status between sequencer and datapath.
	awm_pkg::cmd_t cmd;
	awm_pkg::sts_t sts;

	// The sequencer decodes the captured word and walks the datapath through
	// the table scan, the snooze arithmetic or the table update.
	awm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// The datapath holds the table, the active alarm with its snooze count
	// and the output register that decouples rsp from the next word.
	awm_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ===== bench/awm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awm_checker
// Watches both channels of the alarm matcher, predicts each result word and
// compares it field by field with the word that the block returns.
// ----------------------------------------------------------------------------
module awm_checker #(
	parameter int ENTRIES = awm_pkg::ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	awm_in_if    req,
	awm_out_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   words_in,
	output int   rings_seen,
	output int   slot_errors
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic            ringing;
		logic            error;
		awm_pkg::entry_t entry;
	} reply_t;

	awm_pkg::entry_t slot_store [ENTRIES];
	awm_pkg::entry_t live_alarm;
	logic            live_valid;
	logic [7:0]      snoozes;
	reply_t          reply_q [$];

	task automatic report_mismatch(input string msg);
		if (fail_count < 40) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic void drop_alarm();
		live_valid = 1'b0;
		live_alarm = '0;
		snoozes    = '0;
	endfunction

	// Tick while an alarm is live: decide from mode, count and the snoozed time.
	function automatic logic rings_again(input logic [4:0] hr, input logic [5:0] mn);
		int limit;
		int th;
		int tm;
		case (live_alarm.snz_mode)
			awm_pkg::MODE_ONE:       limit = 1;
			awm_pkg::MODE_THREE:     limit = 3;
			awm_pkg::MODE_FIVE:      limit = 5;
			awm_pkg::MODE_UNLIMITED: limit = 255;
			default:                 limit = -1;
		endcase
		if (limit < 0 || int'(snoozes) > limit) begin
			drop_alarm();
			return 1'b0;
		end
		th = int'(live_alarm.hour);
		tm = (int'(live_alarm.minute) + int'(snoozes) * int'(live_alarm.snooze_length)) & 'hFF;
		// The hour wrap is tested at least once, even when no minute carry happens.
		do begin
			if (tm > int'(awm_pkg::MINUTE_LAST)) begin
				th++;
				tm -= int'(awm_pkg::MINUTES_HOUR);
			end
			if (th > int'(awm_pkg::HOUR_LAST)) begin
				th -= int'(awm_pkg::HOURS_DAY);
			end
		end while (tm > int'(awm_pkg::MINUTE_LAST));
		return (th >= int'(hr)) && (tm >= int'(mn));
	endfunction

	// Tick with nothing live: the first matching slot becomes the live alarm.
	function automatic logic scan_table(input logic [4:0] hr, input logic [5:0] mn,
			input logic [2:0] wd);
		int i;
		if (wd == 3'd0) begin
			return 1'b0;
		end
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_store[i].hour == hr && slot_store[i].minute == mn &&
					slot_store[i].day_mask[wd - 3'd1]) begin
				live_alarm = slot_store[i];
				live_valid = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic reply_t predict_reply(input logic [2:0] act, input logic [4:0] hr,
			input logic [5:0] mn, input logic [2:0] wd, input logic [7:0] slot,
			input logic [3:0] len, input logic [3:0] mode, input logic [6:0] days);
		reply_t r;
		logic   hit;
		int     i;
		r   = '0;
		hit = int'(slot) < ENTRIES;
		case (act)
			awm_pkg::ACT_TICK: begin
				r.ringing = live_valid ? rings_again(hr, mn) : scan_table(hr, mn, wd);
			end
			awm_pkg::ACT_SNOOZE: begin
				snoozes = snoozes + 8'd1;
			end
			awm_pkg::ACT_DISMISS: begin
				drop_alarm();
			end
			awm_pkg::ACT_SET: begin
				if (hit) begin
					slot_store[slot[IDX_W-1:0]] = '{day_mask: days, snz_mode: mode,
						snooze_length: len, hour: hr, minute: mn};
				end else begin
					r.error = 1'b1;
				end
			end
			awm_pkg::ACT_CLEAR: begin
				if (hit) begin
					slot_store[slot[IDX_W-1:0]] = '0;
				end else begin
					r.error = 1'b1;
				end
			end
			awm_pkg::ACT_CLEAR_ALL: begin
				for (i = 0; i < ENTRIES; i++) begin
					slot_store[i] = '0;
				end
			end
			awm_pkg::ACT_READ: begin
				if (hit) begin
					r.entry = slot_store[slot[IDX_W-1:0]];
				end else begin
					r.error = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_reply();
		reply_t want;
		if (reply_q.size() == 0) begin
			report_mismatch("result word arrived with no request outstanding");
			return;
		end
		want = reply_q.pop_front();
		compare_field("ringing", 8'(rsp.ringing), 8'(want.ringing));
		compare_field("error", 8'(rsp.error), 8'(want.error));
		compare_field("entry_hour", 8'(rsp.entry_hour), 8'(want.entry.hour));
		compare_field("entry_minute", 8'(rsp.entry_minute), 8'(want.entry.minute));
		compare_field("entry_snooze_length", 8'(rsp.entry_snooze_length),
			8'(want.entry.snooze_length));
		compare_field("entry_snz_mode", 8'(rsp.entry_snz_mode), 8'(want.entry.snz_mode));
		compare_field("entry_day_mask", 8'(rsp.entry_day_mask), 8'(want.entry.day_mask));
	endtask

	// Results are taken before requests so that a word leaving in the same
	// cycle as a new one arrives is matched against the older expectation.
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t next;
		if (!arst_n) begin
			foreach (slot_store[i]) begin
				slot_store[i] = '0;
			end
			drop_alarm();
			reply_q.delete();
			fail_count  = 0;
			pending     = 0;
			words_in    = 0;
			rings_seen  = 0;
			slot_errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				check_reply();
			end
			if (req.valid && req.ready) begin
				next = predict_reply(req.action, req.hour, req.minute, req.weekday, req.slot,
					req.snooze_length, req.snz_mode, req.day_mask);
				reply_q.push_back(next);
				words_in++;
				if (next.ringing) begin
					rings_seen++;
				end
				if (next.error) begin
					slot_errors++;
				end
			end
			pending = reply_q.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the weekly alarm matcher with snooze.
// ----------------------------------------------------------------------------
// A short directed run walks the corners first: reads of an empty table,
// writes to the first and last slot and to slots past the end, a tick on
// weekday zero, a ring that snoozes past midnight, a count that runs over
// its limit, an illegal mode that dismisses, out-of-range hour and minute
// values kept in the table, the spare action code and clear all. Random
// alarm sessions follow, each a set, a tick at its time and a string of
// snoozes, reads and ticks, mixed with words of pure noise. The checker
// beside the block does all of the predicting and comparing.
// ----------------------------------------------------------------------------
module testbench;

	localparam int         ENTRIES     = awm_pkg::ENTRIES_DEF;
	localparam logic [2:0] ACT_SPARE   = 3'd7;
	localparam int         WORD_TARGET = 500;
	// Stretch of request words sent without any gaps.
	localparam int         CALM_FROM   = 250;
	localparam int         CALM_TO     = 330;
	// Receiver schedule, in cycles after reset: one long hold-off that backs
	// the block up, then a stretch where the receiver never stalls.
	localparam int         HOLD_START  = 1500;
	localparam int         HOLD_LEN    = 300;
	localparam int         RDY_CALM_A  = 3000;
	localparam int         RDY_CALM_B  = 4000;

	logic clk;
	logic arst_n;
	int   sent;
	int   fail_count;
	int   pending;
	int   words_in;
	int   rings_seen;
	int   slot_errors;

	awm_in_if  req ();
	awm_out_if rsp ();

	weekly_alarm_matcher_with_snooze #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	awm_checker #(
		.ENTRIES(ENTRIES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.words_in    (words_in),
		.rings_seen  (rings_seen),
		.slot_errors (slot_errors)
	);

	always #1 clk = ~clk;

	// Offer one request word and hold it until the block takes it. Now and
	// then the valid line drops for a random gap first, except in the calm
	// stretch, so that gaps land at every point of the block's sequencing.
	task automatic issue(input logic [2:0] act, input logic [4:0] hr, input logic [5:0] mn,
			input logic [2:0] wd, input logic [7:0] slot, input logic [3:0] len,
			input logic [3:0] mode, input logic [6:0] days);
		int gap;
		if (!(sent >= CALM_FROM && sent < CALM_TO) && $urandom_range(99) < 11) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.action        <= act;
		req.hour          <= hr;
		req.minute        <= mn;
		req.weekday       <= wd;
		req.slot          <= slot;
		req.snooze_length <= len;
		req.snz_mode      <= mode;
		req.day_mask      <= days;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Fields that an action ignores still get random values, so that the
	// block is seen to ignore them.
	task automatic set_alarm(input logic [7:0] slot, input logic [4:0] hr, input logic [5:0] mn,
			input logic [3:0] len, input logic [3:0] mode, input logic [6:0] days);
		issue(awm_pkg::ACT_SET, hr, mn, 3'($urandom), slot, len, mode, days);
	endtask

	task automatic tick(input logic [4:0] hr, input logic [5:0] mn, input logic [2:0] wd);
		issue(awm_pkg::ACT_TICK, hr, mn, wd, 8'($urandom), 4'($urandom), 4'($urandom),
			7'($urandom));
	endtask

	task automatic slot_op(input logic [2:0] act, input logic [7:0] slot);
		issue(act, 5'($urandom), 6'($urandom), 3'($urandom), slot, 4'($urandom),
			4'($urandom), 7'($urandom));
	endtask

	task automatic act_only(input logic [2:0] act);
		issue(act, 5'($urandom), 6'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
			4'($urandom), 7'($urandom));
	endtask

	// A well-formed session: store an alarm, tick at its time mostly on an
	// enabled day so it becomes live, then snooze, read and tick around it.
	// Mostly modes are legal one-hot codes and times lie on the clock face.
	task automatic alarm_session();
		logic [7:0] slot;
		logic [4:0] hr;
		logic [5:0] mn;
		logic [3:0] mode;
		logic [2:0] wd;
		logic [6:0] days;
		int         steps;
		slot = 8'($urandom_range(ENTRIES - 1));
		hr   = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23));
		mn   = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59));
		case ($urandom_range(9))
			0:       mode = 4'($urandom);
			1, 2:    mode = awm_pkg::MODE_ONE;
			3, 4:    mode = awm_pkg::MODE_THREE;
			5, 6:    mode = awm_pkg::MODE_FIVE;
			default: mode = awm_pkg::MODE_UNLIMITED;
		endcase
		wd   = 3'($urandom_range(1, 7));
		days = 7'($urandom) | (7'd1 << (wd - 3'd1));
		set_alarm(slot, hr, mn, 4'($urandom), mode, days);
		// Sometimes a second slot shares the time, so scan order matters.
		if ($urandom_range(3) == 0) begin
			set_alarm(8'($urandom_range(ENTRIES - 1)), hr, mn, 4'($urandom), 4'($urandom),
				7'($urandom));
		end
		tick(hr, mn, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : wd);
		steps = $urandom_range(2, 9);
		repeat (steps) begin
			case ($urandom_range(7))
				0, 1, 2: act_only(awm_pkg::ACT_SNOOZE);
				3:       slot_op(awm_pkg::ACT_READ, 8'($urandom_range(ENTRIES - 1)));
				default: tick(5'(hr + 5'($urandom_range(1))), 6'($urandom_range(63)), wd);
			endcase
		end
		if ($urandom_range(9) < 7) begin
			act_only(awm_pkg::ACT_DISMISS);
		end
	endtask

	// Any action with fully random fields, slot numbers often past the end.
	task automatic noise_word();
		issue(3'($urandom_range(7)), 5'($urandom), 6'($urandom), 3'($urandom),
			($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(ENTRIES - 1)),
			4'($urandom), 4'($urandom), 7'($urandom));
	endtask

	// Receiver: random stalls, one long hold-off while the sender keeps
	// offering words, and a stretch with no stalls at all.
	initial begin : result_sink
		int cyc;
		cyc       = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
				rsp.ready <= 1'b0;
			end else if (cyc >= RDY_CALM_A && cyc < RDY_CALM_B) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin : stimulus
		clk               = 1'b0;
		arst_n            = 1'b0;
		sent              = 0;
		req.valid         = 1'b0;
		req.action        = awm_pkg::ACT_TICK;
		req.hour          = '0;
		req.minute        = '0;
		req.weekday       = '0;
		req.slot          = '0;
		req.snooze_length = '0;
		req.snz_mode      = '0;
		req.day_mask      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners.
		slot_op(awm_pkg::ACT_READ, 8'd0);
		set_alarm(8'd0, 5'd23, 6'd59, 4'd15, awm_pkg::MODE_ONE, 7'h7F);
		set_alarm(8'(ENTRIES - 1), 5'd0, 6'd0, 4'd0, awm_pkg::MODE_UNLIMITED, 7'h40);
		set_alarm(8'(ENTRIES), 5'd12, 6'd30, 4'd5, awm_pkg::MODE_FIVE, 7'h01);
		set_alarm(8'd255, 5'd12, 6'd30, 4'd5, awm_pkg::MODE_FIVE, 7'h01);
		slot_op(awm_pkg::ACT_READ, 8'd0);
		slot_op(awm_pkg::ACT_READ, 8'(ENTRIES - 1));
		slot_op(awm_pkg::ACT_READ, 8'd255);
		// Weekday zero matches nothing, even with every day enabled.
		tick(5'd23, 6'd59, 3'd0);
		tick(5'd23, 6'd59, 3'd7);
		tick(5'd23, 6'd59, 3'd7);
		// One snooze of fifteen minutes carries the alarm past midnight.
		act_only(awm_pkg::ACT_SNOOZE);
		tick(5'd0, 6'd0, 3'd1);
		// A second snooze exceeds the single allowed one and dismisses.
		act_only(awm_pkg::ACT_SNOOZE);
		tick(5'd0, 6'd0, 3'd1);
		// Nothing live now, so the scan finds the last slot on a Sunday.
		tick(5'd0, 6'd0, 3'd7);
		act_only(awm_pkg::ACT_DISMISS);
		slot_op(awm_pkg::ACT_CLEAR, 8'(ENTRIES - 1));
		slot_op(awm_pkg::ACT_CLEAR, 8'd200);
		// Out-of-range time kept as stored, with an illegal mode.
		set_alarm(8'd3, 5'd31, 6'd63, 4'd15, 4'hF, 7'h01);
		tick(5'd31, 6'd63, 3'd1);
		tick(5'd31, 6'd63, 3'd1);
		act_only(ACT_SPARE);
		act_only(awm_pkg::ACT_CLEAR_ALL);
		slot_op(awm_pkg::ACT_READ, 8'd3);

		// Random part: mostly alarm sessions, the rest noise.
		while (sent < WORD_TARGET) begin
			if ($urandom_range(9) < 7) begin
				alarm_session();
			end else begin
				noise_word();
			end
		end
		req.valid <= 1'b0;

		// Let the checker see the last word, drain, then allow for the
		// longest scan in case anything stray comes out.
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);

		$display("Run sent %0d request words: %0d ticks rang, %0d slot numbers were rejected.",
			words_in, rings_seen, slot_errors);
		$display("Responses were held off for %0d cycles once to back up the request side.",
			HOLD_LEN);
		if (fail_count == 0) begin
			$display("** weekly_alarm_matcher_with_snooze: PASSED **");
		end else begin
			$display("** weekly_alarm_matcher_with_snooze: FAILED **");
		end
		$finish;
	end

	// A correct run ends long before this timeout.
	initial begin : watchdog
		#500_000;
		$display("** weekly_alarm_matcher_with_snooze: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
sv/awm_pkg.sv
sv/awm_in_if.sv
sv/awm_out_if.sv
sv/awm_ram.sv
sv/awm_ctrl.sv
sv/awm_dp.sv
sv/weekly_alarm_matcher_with_snooze.sv
bench/awm_checker.sv
bench/testbench.sv
